@@ src/pcpo_pkg.sv @@
// shared types for the point circle push-out pipeline
`default_nettype none
package pcpo_pkg;

  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned DIV_STAGES  = 32;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [30:0] radius;
  } req_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic               pushed;
    logic               degenerate;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               neg_x;
    logic               neg_y;
    logic               hit;
    logic               degen;
    logic        [61:0] mx;
    logic        [61:0] my;
  } side_t;

endpackage
`default_nettype wire

@@ src/pcpo_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`default_nettype none
module pcpo_sqrt (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [61:0]          in_s,
  input  wire pcpo_pkg::side_t      in_side,
  output logic                      out_valid,
  output logic [30:0]               out_len,
  output pcpo_pkg::side_t           out_side
);

  localparam int unsigned N = pcpo_pkg::SQRT_STAGES;

  logic                 v    [0:N];
  logic [32:0]          rem  [0:N];
  logic [30:0]          root [0:N];
  logic [61:0]          sv   [0:N];
  pcpo_pkg::side_t      side [0:N];

  assign v[0]    = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sv[0]   = in_s;
  assign side[0] = in_side;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [34:0] cur;
    logic [34:0] trial;
    logic        take;

    always_comb begin
      cur   = {rem[k], sv[k][61:60]};
      trial = {2'b00, root[k], 2'b01};
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      rem[k+1]  <= take ? 33'(cur - trial) : cur[32:0];
      root[k+1] <= {root[k][29:0], take};
      sv[k+1]   <= {sv[k][59:0], 2'b00};
      side[k+1] <= side[k];
    end
  end

  assign out_valid = v[N];
  assign out_len   = root[N];
  assign out_side  = side[N];

endmodule
`default_nettype wire

@@ src/pcpo_div.sv @@
// pipelined restoring divider, both axes share the divisor
`default_nettype none
module pcpo_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [30:0]          in_len,
  input  wire logic [62:0]          in_num_x,
  input  wire logic [62:0]          in_num_y,
  input  wire pcpo_pkg::side_t      in_side,
  output logic                      out_valid,
  output logic [31:0]               out_q_x,
  output logic [31:0]               out_q_y,
  output pcpo_pkg::side_t           out_side
);

  localparam int unsigned N = pcpo_pkg::DIV_STAGES;

  logic                 v    [0:N];
  logic [30:0]          len  [0:N];
  logic [30:0]          rx   [0:N];
  logic [30:0]          ry   [0:N];
  logic [31:0]          nx   [0:N];
  logic [31:0]          ny   [0:N];
  logic [31:0]          qx   [0:N];
  logic [31:0]          qy   [0:N];
  pcpo_pkg::side_t      side [0:N];

  assign v[0]    = in_valid;
  assign len[0]  = in_len;
  assign rx[0]   = in_num_x[62:32];
  assign ry[0]   = in_num_y[62:32];
  assign nx[0]   = in_num_x[31:0];
  assign ny[0]   = in_num_y[31:0];
  assign qx[0]   = '0;
  assign qy[0]   = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0] cx;
    logic [31:0] cy;
    logic        tx;
    logic        ty;

    always_comb begin
      cx = {rx[k], nx[k][31]};
      cy = {ry[k], ny[k][31]};
      tx = (cx >= {1'b0, len[k]});
      ty = (cy >= {1'b0, len[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      len[k+1]  <= len[k];
      rx[k+1]   <= tx ? 31'(cx - {1'b0, len[k]}) : cx[30:0];
      ry[k+1]   <= ty ? 31'(cy - {1'b0, len[k]}) : cy[30:0];
      nx[k+1]   <= {nx[k][30:0], 1'b0};
      ny[k+1]   <= {ny[k][30:0], 1'b0};
      qx[k+1]   <= {qx[k][30:0], tx};
      qy[k+1]   <= {qy[k][30:0], ty};
      side[k+1] <= side[k];
    end
  end

  assign out_valid = v[N];
  assign out_q_x   = qx[N];
  assign out_q_y   = qy[N];
  assign out_side  = side[N];

endmodule
`default_nettype wire

@@ src/point_circle_push_out.sv @@
// top level: pushes a point inside a circle out onto its boundary
//
// one request beat is taken at each rising edge with start high and busy low;
// busy stays low, so a new beat may enter every cycle
// req carries the point, the circle center and the radius, raw Q16.16 values
// each beat gives exactly one response beat on rsp, marked by done for one
// cycle, in the order the requests came in
// pipeline: 69 register stages, the capture register loading at the accepting edge:
//   4 stages of capture, offset, squaring and inside test, 31 square root
//   stages, 1 rounding add, 32 divider stages and the output register
// throughput: one beat per cycle, set by the fully pipelined root and divider
// the response side cannot stall; every beat is delivered once
// reset clears all valid bits, so no done follows reset until new beats enter
// a point on the center passes unchanged with degenerate set
`default_nettype none
module point_circle_push_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire pcpo_pkg::req_t  req,
  output logic                 done,
  output pcpo_pkg::rsp_t       rsp
);

  assign busy = 1'b0;

  // stage 0: capture
  logic            v0;
  pcpo_pkg::req_t  r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    r0 <= req;
  end

  // stage 1: offsets
  logic signed [32:0] dx, dy;
  logic [32:0] adx_c, ady_c;

  always_comb begin
    dx    = {r0.point_x[31], r0.point_x} - {r0.center_x[31], r0.center_x};
    dy    = {r0.point_y[31], r0.point_y} - {r0.center_y[31], r0.center_y};
    adx_c = dx[32] ? 33'(-dx) : 33'(dx);
    ady_c = dy[32] ? 33'(-dy) : 33'(dy);
  end

  logic        v1, small1, degen1, negx1, negy1;
  logic [30:0] adx1, ady1, r1;
  logic signed [31:0] px1, py1, cx1, cy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    small1 <= (adx_c <= {2'b00, r0.radius}) && (ady_c <= {2'b00, r0.radius});
    degen1 <= (dx == '0) && (dy == '0);
    negx1  <= dx[32];
    negy1  <= dy[32];
    adx1   <= adx_c[30:0];
    ady1   <= ady_c[30:0];
    r1     <= r0.radius;
    px1    <= r0.point_x;
    py1    <= r0.point_y;
    cx1    <= r0.center_x;
    cy1    <= r0.center_y;
  end

  // stage 2: products
  logic        v2, small2, degen2, negx2, negy2;
  logic [61:0] sqx2, sqy2, rr2, mx2, my2;
  logic signed [31:0] px2, py2, cx2, cy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sqx2   <= adx1 * adx1;
    sqy2   <= ady1 * ady1;
    rr2    <= r1 * r1;
    mx2    <= adx1 * r1;
    my2    <= ady1 * r1;
    small2 <= small1;
    degen2 <= degen1;
    negx2  <= negx1;
    negy2  <= negy1;
    px2    <= px1;
    py2    <= py1;
    cx2    <= cx1;
    cy2    <= cy1;
  end

  // stage 3: inside test
  logic [62:0] s_c;
  assign s_c = {1'b0, sqx2} + {1'b0, sqy2};

  logic            v3;
  logic [61:0]     s3;
  pcpo_pkg::side_t side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3          <= s_c[61:0];
    side3.px    <= px2;
    side3.py    <= py2;
    side3.cx    <= cx2;
    side3.cy    <= cy2;
    side3.neg_x <= negx2;
    side3.neg_y <= negy2;
    side3.hit   <= small2 && !degen2 && (s_c <= {1'b0, rr2});
    side3.degen <= degen2;
    side3.mx    <= mx2;
    side3.my    <= my2;
  end

  // square root
  logic            v4;
  logic [30:0]     len4;
  pcpo_pkg::side_t side4;

  pcpo_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_s      (s3),
    .in_side   (side3),
    .out_valid (v4),
    .out_len   (len4),
    .out_side  (side4)
  );

  // rounding add
  logic            v5;
  logic [30:0]     len5;
  logic [62:0]     numx5, numy5;
  pcpo_pkg::side_t side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    len5  <= len4;
    numx5 <= {1'b0, side4.mx} + {33'd0, len4[30:1]};
    numy5 <= {1'b0, side4.my} + {33'd0, len4[30:1]};
    side5 <= side4;
  end

  // divide
  logic            v6;
  logic [31:0]     qx6, qy6;
  pcpo_pkg::side_t side6;

  pcpo_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_len    (len5),
    .in_num_x  (numx5),
    .in_num_y  (numy5),
    .in_side   (side5),
    .out_valid (v6),
    .out_q_x   (qx6),
    .out_q_y   (qy6),
    .out_side  (side6)
  );

  // sign, add center, saturate
  logic signed [33:0] offx, offy, sumx, sumy;
  logic signed [31:0] satx, saty;

  always_comb begin
    offx = side6.neg_x ? -$signed({2'b00, qx6}) : $signed({2'b00, qx6});
    offy = side6.neg_y ? -$signed({2'b00, qy6}) : $signed({2'b00, qy6});
    sumx = {{2{side6.cx[31]}}, side6.cx} + offx;
    sumy = {{2{side6.cy[31]}}, side6.cy} + offy;
    if (sumx > 34'sh0_7FFF_FFFF) begin
      satx = 32'sh7FFF_FFFF;
    end else if (sumx < -34'sh0_8000_0000) begin
      satx = 32'sh8000_0000;
    end else begin
      satx = sumx[31:0];
    end
    if (sumy > 34'sh0_7FFF_FFFF) begin
      saty = 32'sh7FFF_FFFF;
    end else if (sumy < -34'sh0_8000_0000) begin
      saty = 32'sh8000_0000;
    end else begin
      saty = sumy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
    rsp.new_x      <= side6.hit ? satx : side6.px;
    rsp.new_y      <= side6.hit ? saty : side6.py;
    rsp.pushed     <= side6.hit;
    rsp.degenerate <= side6.degen;
  end

`ifndef ASSERT_OFF
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.pushed && rsp.degenerate))
    else $error("pushed and degenerate both set");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("response beat right after reset");

  a_hit_not_degen: assert property (@(posedge clk) disable iff (rst)
    v3 && side3.hit |-> !side3.degen)
    else $error("degenerate point marked inside");

  a_degen_passes: assert property (@(posedge clk) disable iff (rst)
    v6 && side6.degen |=> done && rsp.new_x == $past(side6.px)
      && rsp.new_y == $past(side6.py))
    else $error("degenerate point was moved");
`endif

endmodule
`default_nettype wire

@@ verif/point_circle_push_out_checker.sv @@
// checker module: predicts each push-out response and compares it with the block's output
`timescale 1ns / 1ps
module point_circle_push_out_checker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            busy,
  input  wire pcpo_pkg::req_t  req,
  input  wire logic            done,
  input  wire pcpo_pkg::rsp_t  rsp,
  output int                   fail_count,
  output int                   pending,
  output int                   beats_seen,
  output int                   pushes_seen,
  output int                   degens_seen
);

  pcpo_pkg::rsp_t expected_q[$];

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res = 0;
    rem = n;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic pcpo_pkg::rsp_t push_out(input pcpo_pkg::req_t q);
    pcpo_pkg::rsp_t o;
    logic signed [63:0] dx, dy, offx, offy;
    logic [63:0] ax, ay, r, s, len, mx, my;
    dx = 64'(q.point_x) - 64'(q.center_x);
    dy = 64'(q.point_y) - 64'(q.center_y);
    ax = dx < 0 ? 64'(-dx) : 64'(dx);
    ay = dy < 0 ? 64'(-dy) : 64'(dy);
    r = {33'd0, q.radius};
    o.new_x = q.point_x;
    o.new_y = q.point_y;
    o.pushed = 1'b0;
    o.degenerate = 1'b0;
    if (dx == 0 && dy == 0) begin
      o.degenerate = 1'b1;
    end else if (ax <= r && ay <= r) begin
      s = ax * ax + ay * ay;
      if (s <= r * r) begin
        len = root_floor(s);
        mx = (ax * r + (len >> 1)) / len;
        my = (ay * r + (len >> 1)) / len;
        offx = dx < 0 ? -$signed(mx) : $signed(mx);
        offy = dy < 0 ? -$signed(my) : $signed(my);
        o.new_x = clamp32(64'(q.center_x) + offx);
        o.new_y = clamp32(64'(q.center_y) + offy);
        o.pushed = 1'b1;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    pcpo_pkg::rsp_t e;
    if (rst) begin
      fail_count <= 0;
      beats_seen <= 0;
      pushes_seen <= 0;
      degens_seen <= 0;
      pending <= 0;
    end else begin
      if (start && !busy) expected_q.push_back(push_out(req));
      if (done) begin
        beats_seen <= beats_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected response beat %p", rsp);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          pushes_seen <= pushes_seen + e.pushed;
          degens_seen <= degens_seen + e.degenerate;
          if (rsp.new_x !== e.new_x || rsp.new_y !== e.new_y ||
              rsp.pushed !== e.pushed || rsp.degenerate !== e.degenerate) begin
            if (fail_count < 10)
              $display("mismatch: expected x=%h y=%h p=%b d=%b got x=%h y=%h p=%b d=%b",
                       e.new_x, e.new_y, e.pushed, e.degenerate,
                       rsp.new_x, rsp.new_y, rsp.pushed, rsp.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

@@ verif/point_circle_push_out_tb.sv @@
// testbench top: drives push-out requests in bursts and reports the verdict
`timescale 1ns / 1ps
module point_circle_push_out_tb;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  pcpo_pkg::req_t req = '0;
  pcpo_pkg::rsp_t rsp;
  int fail_count, pending, beats_seen, pushes_seen, degens_seen;
  int sent = 0;

  point_circle_push_out dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  point_circle_push_out_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending),
    .beats_seen(beats_seen), .pushes_seen(pushes_seen), .degens_seen(degens_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] rand32();
    return $urandom();
  endfunction

  // mostly points near the circle so pushes happen often
  function automatic pcpo_pkg::req_t random_req();
    pcpo_pkg::req_t q;
    int unsigned mode;
    logic [30:0] r;
    mode = $urandom_range(0, 9);
    q.center_x = rand32();
    q.center_y = rand32();
    case ($urandom_range(0, 3))
      0: r = 31'($urandom_range(0, 15));
      1: r = 31'($urandom_range(0, 32'h0010_0000));
      2: r = 31'($urandom());
      default: r = 31'(31'h7fff_ffff - $urandom_range(0, 255));
    endcase
    q.radius = r;
    if (mode < 6) begin
      q.point_x = q.center_x + $signed(32'($urandom_range(0, r))) *
                  ($urandom_range(0, 1) ? 1 : -1);
      q.point_y = q.center_y + $signed(32'($urandom_range(0, r))) *
                  ($urandom_range(0, 1) ? 1 : -1);
    end else if (mode == 6) begin
      q.point_x = q.center_x;
      q.point_y = q.center_y;
    end else begin
      q.point_x = rand32();
      q.point_y = rand32();
    end
    return q;
  endfunction

  task automatic send(input pcpo_pkg::req_t q);
    start <= 1'b1;
    req <= q;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic pause();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_beats();
    pcpo_pkg::req_t q;
    q = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0};
    send(q);
    q.radius = 31'h7fff_ffff;
    send(q);
    q = '{32'sd5, 32'sd0, 32'sd0, 32'sd0, 31'd0};
    send(q);
    q = '{32'sd3, 32'sd4, 32'sd0, 32'sd0, 31'd5};
    send(q);
    q = '{32'sd3, 32'sd4, 32'sd0, 32'sd0, 31'd4};
    send(q);
    q = '{32'sd1, -32'sd1, 32'sd0, 32'sd0, 31'h10000};
    send(q);
    q = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_fff0, 32'sh7fff_fff0,
          31'h7fff_ffff};
    send(q);
    q = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0010, 32'sh8000_0010,
          31'h7fff_ffff};
    send(q);
    q = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
          31'h7fff_ffff};
    send(q);
    q = '{32'sh7fff_ffff, 32'sh0, 32'sh8000_0000, 32'sh0, 31'h7fff_ffff};
    send(q);
    q = '{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 31'h0001_0000};
    send(q);
    q = '{-32'sd1, -32'sd1, 32'sd0, 32'sd0, 31'd2};
    send(q);
    q = '{32'sd0, 32'sd7, 32'sd0, 32'sd0, 31'd100};
    send(q);
    q = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
          31'h5555_5555};
    send(q);
    q = '{32'shffff_ffff, 32'sh0, 32'sh0, 32'sh0, 31'h7fff_ffff};
    send(q);
  endtask

  initial begin
    int burst;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_beats();
    pause();
    while (sent < 1350) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send(random_req());
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("sent %0d request beats, checked %0d responses", sent, beats_seen);
    $display("%0d pushed onto the circle, %0d point-on-center cases",
             pushes_seen, degens_seen);
    if (fail_count == 0) begin
      $display("point_circle_push_out verification clean");
    end else begin
      $display("point_circle_push_out verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("point_circle_push_out verification failed");
    $finish;
  end
endmodule

@@ files.f @@
src/pcpo_pkg.sv
src/pcpo_sqrt.sv
src/pcpo_div.sv
src/point_circle_push_out.sv
verif/point_circle_push_out_checker.sv
verif/point_circle_push_out_tb.sv
